/* rtl/wsfu_pkg.sv */
// ----------------------------------------------------------------------------
// wsfu_pkg
// Shared types and constants for the frame unmasker: result kinds, the
// result record passed from the deframer to the output stage, and header codes.
// ----------------------------------------------------------------------------
package wsfu_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  localparam logic [6:0] LEN7_ESC16 = 7'd126;
  localparam logic [6:0] LEN7_ESC64 = 7'd127;
  localparam int unsigned MASK_BIT  = 7;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last;
    logic [63:0] message_length;
  } result_t;

endpackage

/* rtl/wsfu_deframer.sv */
// ----------------------------------------------------------------------------
// wsfu_deframer
// Header, length and mask key parser with payload unmasking. Holds the frame
// state and presents at most one result for the current beat combinationally.
// ----------------------------------------------------------------------------
module wsfu_deframer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        rx_byte_i,
  output wsfu_pkg::result_t res_o
);
  import wsfu_pkg::*;

  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_EXT16 = 3'd2;
  localparam logic [2:0] PH_EXT64 = 3'd3;
  localparam logic [2:0] PH_MASK  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [63:0] flen_q, flen_d;
  logic [31:0] mkey_q, mkey_d;
  logic [63:0] remain_q, remain_d;
  logic [1:0]  idx_q, idx_d;
  logic        masked_q, masked_d;
  logic        halted_q, halted_d;

  logic [63:0] flen_shift;
  logic [7:0]  mask_byte;
  logic        fin;

  assign flen_shift = {flen_q[55:0], rx_byte_i};
  assign fin        = (remain_q == 64'd1);

  always_comb begin
    unique case (idx_q)
      2'd0:    mask_byte = mkey_q[31:24];
      2'd1:    mask_byte = mkey_q[23:16];
      2'd2:    mask_byte = mkey_q[15:8];
      default: mask_byte = mkey_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    flen_d   = flen_q;
    mkey_d   = mkey_q;
    remain_d = remain_q;
    idx_d    = idx_q;
    masked_d = masked_q;
    halted_d = halted_q;
    res_o    = '{valid: 1'b0, kind: KIND_PAYLOAD, payload_byte: 8'd0,
                 last: 1'b0, message_length: 64'd0};
    if (!halted_q) begin
      unique case (phase_q)
        PH_LEN: begin
          masked_d = rx_byte_i[MASK_BIT];
          mkey_d   = 32'd0;
          idx_d    = 2'd0;
          cnt_d    = 3'd0;
          if (rx_byte_i[6:0] == LEN7_ESC16) begin
            flen_d  = 64'd0;
            phase_d = PH_EXT16;
          end else if (rx_byte_i[6:0] == LEN7_ESC64) begin
            flen_d  = 64'd0;
            phase_d = PH_EXT64;
          end else begin
            flen_d = {57'd0, rx_byte_i[6:0]};
            if (!rx_byte_i[MASK_BIT]) begin
              halted_d = 1'b1;
              phase_d  = PH_HDR0;
              res_o    = '{valid: 1'b1, kind: KIND_ERROR, payload_byte: 8'd0,
                           last: 1'b1, message_length: {57'd0, rx_byte_i[6:0]}};
            end else begin
              phase_d = PH_MASK;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          flen_d = flen_shift;
          if (cnt_q == ((phase_q == PH_EXT16) ? 3'd1 : 3'd7)) begin
            cnt_d = 3'd0;
            if (!masked_q) begin
              halted_d = 1'b1;
              phase_d  = PH_HDR0;
              res_o    = '{valid: 1'b1, kind: KIND_ERROR, payload_byte: 8'd0,
                           last: 1'b1, message_length: flen_shift};
            end else begin
              phase_d = PH_MASK;
            end
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_MASK: begin
          mkey_d = {mkey_q[23:0], rx_byte_i};
          if (cnt_q < 3'd3) begin
            cnt_d = cnt_q + 3'd1;
          end else begin
            cnt_d    = 3'd0;
            idx_d    = 2'd0;
            remain_d = flen_q;
            if (flen_q == 64'd0) begin
              phase_d = PH_HDR0;
              res_o   = '{valid: 1'b1, kind: KIND_EMPTY, payload_byte: 8'd0,
                          last: 1'b1, message_length: 64'd0};
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          res_o    = '{valid: 1'b1, kind: KIND_PAYLOAD,
                       payload_byte: rx_byte_i ^ mask_byte,
                       last: fin, message_length: flen_q};
          idx_d    = idx_q + 2'd1;
          remain_d = remain_q - 64'd1;
          if (fin) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          phase_d = PH_LEN;
          cnt_d   = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      cnt_q    <= 3'd0;
      flen_q   <= 64'd0;
      mkey_q   <= 32'd0;
      remain_q <= 64'd0;
      idx_q    <= 2'd0;
      masked_q <= 1'b0;
      halted_q <= 1'b0;
    end else if (beat_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      flen_q   <= flen_d;
      mkey_q   <= mkey_d;
      remain_q <= remain_d;
      idx_q    <= idx_d;
      masked_q <= masked_d;
      halted_q <= halted_d;
    end
  end

endmodule

/* rtl/websocket_frame_unmasker.sv */
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Deframes a client-to-server WebSocket byte stream and unmasks the payload.
//
// Input channel: one received byte per beat on rx_byte_i (in_valid_i /
// in_ready_o). Output channel: one result per beat (out_valid_o /
// out_ready_i) carrying kind, payload_byte, last and message_length.
// Header, extended length and mask key bytes produce no result; each payload
// byte produces one, a zero-length frame produces one empty-message result,
// and an unmasked frame produces one error result after which all bytes are
// swallowed until reset.
// Output: a result is registered and appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle while out_ready_i does not hold off the input, set by the
// parser update and the output register.
// Reset: parser returns to waiting for the first header byte, output empty.
// Stall: while a result waits, a new byte is taken only in the cycle the
// result is taken, so out_ready_i low holds off the input.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wsfu_pkg::kind_e    kind_o,
  output logic [7:0]         payload_byte_o,
  output logic               last_o,
  output logic [63:0]        message_length_o
);
  import wsfu_pkg::*;

  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    beat;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign beat       = in_valid_i && in_ready_o;

  wsfu_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .rx_byte_i (rx_byte_i),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= beat && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign payload_byte_o   = out_q.payload_byte;
  assign last_o           = out_q.last;
  assign message_length_o = out_q.message_length;

endmodule

/* tb/tb_websocket_frame_unmasker.sv */
// ----------------------------------------------------------------------------
// tb_websocket_frame_unmasker
// Self-checking testbench for the frame unmasker. Builds client-to-server
// frames (short, 16-bit and 64-bit length forms, empty frames, varied mask
// keys), then random frames, and ends with one unmasked frame followed by
// trailing bytes that must be swallowed. A behavioral deframer in the bench
// predicts every result beat; the monitor compares each output beat field by
// field against the oldest prediction. Random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_websocket_frame_unmasker;
  import wsfu_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0, PH_LEN, PH_EXT16, PH_EXT64, PH_KEY, PH_DATA
  } deframe_phase_e;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

  typedef struct {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last;
    logic [63:0] message_length;
  } result_beat_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  kind_e       kind_o;
  logic [7:0]  payload_byte_o;
  logic        last_o;
  logic [63:0] message_length_o;

  logic [7:0]   rx_stream_q[$];
  result_beat_t expected_results_q[$];
  int           mismatches  = 0;
  int           sent        = 0;
  int           calm_after  = 0;
  int           in_gap      = 0;
  int           out_gap     = 0;
  logic         in_taken    = 1'b0;

  // deframer state
  deframe_phase_e dph_phase  = PH_HDR0;
  logic [2:0]     dph_count  = '0;
  logic [63:0]    dph_len    = '0;
  logic [31:0]    dph_key    = '0;
  logic [63:0]    dph_index  = '0;
  logic           dph_halted = 1'b0;
  logic           dph_masked = 1'b0;

  websocket_frame_unmasker u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .last_o           (last_o),
    .message_length_o (message_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void push_result(input kind_e k, input logic [7:0] pb, input logic l,
                                      input logic [63:0] len);
    result_beat_t r;
    r.kind = k;
    r.payload_byte = pb;
    r.last = l;
    r.message_length = len;
    expected_results_q.push_back(r);
  endfunction

  function automatic void close_length();
    dph_count = '0;
    if (!dph_masked) begin
      dph_halted = 1'b1;
      dph_phase = PH_HDR0;
      push_result(KIND_ERROR, 8'h00, 1'b1, dph_len);
    end else begin
      dph_phase = PH_KEY;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] rx);
    logic [7:0] mb;
    logic       fin;
    if (dph_halted) return;
    case (dph_phase)
      PH_LEN: begin
        dph_masked = rx[MASK_BIT];
        dph_len = {57'd0, rx[6:0]};
        dph_index = '0;
        dph_key = '0;
        dph_count = '0;
        if (rx[6:0] == LEN7_ESC16) begin
          dph_len = '0;
          dph_phase = PH_EXT16;
        end else if (rx[6:0] == LEN7_ESC64) begin
          dph_len = '0;
          dph_phase = PH_EXT64;
        end else begin
          close_length();
        end
      end
      PH_EXT16, PH_EXT64: begin
        dph_len = {dph_len[55:0], rx};
        if (dph_count == ((dph_phase == PH_EXT16) ? 3'd1 : 3'd7)) close_length();
        else dph_count = dph_count + 3'd1;
      end
      PH_KEY: begin
        dph_key = {dph_key[23:0], rx};
        if (dph_count < 3'd3) begin
          dph_count = dph_count + 3'd1;
        end else begin
          dph_count = '0;
          dph_index = '0;
          if (dph_len == 64'd0) begin
            dph_phase = PH_HDR0;
            push_result(KIND_EMPTY, 8'h00, 1'b1, 64'd0);
          end else begin
            dph_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        mb = dph_key[8 * (3 - dph_index[1:0]) +: 8];
        fin = (dph_index == dph_len - 64'd1);
        push_result(KIND_PAYLOAD, rx ^ mb, fin, dph_len);
        dph_index = dph_index + 64'd1;
        if (fin) dph_phase = PH_HDR0;
      end
      default: begin
        dph_phase = PH_LEN;
        dph_count = '0;
      end
    endcase
  endfunction

  task automatic add_frame(input logic [7:0] hdr, input len_form_e form, input logic [63:0] len,
                           input logic masked, input logic [31:0] key);
    rx_stream_q.push_back(hdr);
    case (form)
      LEN_SHORT: rx_stream_q.push_back({masked, len[6:0]});
      LEN_EXT16: begin
        rx_stream_q.push_back({masked, LEN7_ESC16});
        rx_stream_q.push_back(len[15:8]);
        rx_stream_q.push_back(len[7:0]);
      end
      default: begin
        rx_stream_q.push_back({masked, LEN7_ESC64});
        for (int i = 7; i >= 0; i--) rx_stream_q.push_back(len[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) rx_stream_q.push_back(key[8 * i +: 8]);
      for (longint i = 0; i < len; i++) rx_stream_q.push_back(8'($urandom));
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap == 0 && sent < calm_after && $urandom_range(0, 9) == 0)
          in_gap = $urandom_range(1, 9);
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (rx_stream_q.size() > 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_stream_q.pop_front();
          sent++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap == 0 && sent < calm_after && $urandom_range(0, 9) == 0)
        out_gap = $urandom_range(1, 9);
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: check result beats, predict from accepted input beats
  always @(posedge clk_i) begin : monitor
    result_beat_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (expected_results_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat kind %0d", kind_o));
        end else begin
          want = expected_results_q.pop_front();
          if (kind_o != want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", kind_o, want.kind));
          if (payload_byte_o != want.payload_byte)
            flag_mismatch($sformatf("payload_byte %02h, want %02h", payload_byte_o,
                                    want.payload_byte));
          if (last_o != want.last)
            flag_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
          if (message_length_o != want.message_length)
            flag_mismatch($sformatf("message_length %0h, want %0h", message_length_o,
                                    want.message_length));
        end
      end
      if (in_valid_i && in_ready_o) deframe_byte(rx_byte_i);
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int        target;
    len_form_e form;
    logic [63:0] len;
    int        pick;

    // directed frames
    add_frame(8'h00, LEN_SHORT, 64'd0, 1'b1, 32'h0000_0000);
    add_frame(8'hff, LEN_SHORT, 64'd1, 1'b1, 32'hffff_ffff);
    add_frame(8'($urandom), LEN_SHORT, 64'd5, 1'b1, $urandom);
    add_frame(8'($urandom), LEN_EXT16, 64'd0, 1'b1, $urandom);
    add_frame(8'($urandom), LEN_EXT64, 64'd0, 1'b1, $urandom);
    add_frame(8'($urandom), LEN_EXT16, 64'd3, 1'b1, $urandom);
    add_frame(8'($urandom), LEN_EXT64, 64'd2, 1'b1, $urandom);
    add_frame(8'($urandom), LEN_SHORT, 64'd125, 1'b1, $urandom);
    add_frame(8'($urandom), LEN_EXT16, 64'd126, 1'b1, $urandom);
    add_frame(8'($urandom), LEN_EXT16, 64'd257, 1'b1, $urandom);
    add_frame(8'($urandom), LEN_EXT64, 64'd9, 1'b1, $urandom);

    // random frames
    target = rx_stream_q.size() + 250;
    while (rx_stream_q.size() < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        form = LEN_SHORT;
        len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                          : 64'($urandom_range(0, 12));
      end else begin
        form = (pick < 17) ? LEN_EXT16 : LEN_EXT64;
        len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 400))
                                          : 64'($urandom_range(0, 40));
      end
      add_frame(8'($urandom), form, len, 1'b1, $urandom);
    end

    // unmasked frame, then bytes that must be swallowed
    pick = $urandom_range(0, 2);
    if (pick == 0)
      add_frame(8'($urandom), LEN_SHORT, 64'($urandom_range(0, 125)), 1'b0, '0);
    else if (pick == 1)
      add_frame(8'($urandom), LEN_EXT16, 64'($urandom_range(0, 65535)), 1'b0, '0);
    else add_frame(8'($urandom), LEN_EXT64, {$urandom, $urandom}, 1'b0, '0);
    for (int i = 0; i < 20; i++) rx_stream_q.push_back(8'($urandom));

    calm_after = rx_stream_q.size() - 150;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (rx_stream_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (expected_results_q.size() != 0)
      flag_mismatch($sformatf("%0d result beats never arrived", expected_results_q.size()));

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/wsfu_pkg.sv
rtl/wsfu_deframer.sv
rtl/websocket_frame_unmasker.sv
tb/tb_websocket_frame_unmasker.sv
